// ===== rtl/core/target_frame_parser_top_macros.svh =====
// assertion macros for the target frame parser
// expects clk and rst in the scope of each use
`ifndef TARGET_FRAME_PARSER_TOP_MACROS_SVH
`define TARGET_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define TFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("target_frame_parser: assertion failed");

// next-cycle implication
`define TFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("target_frame_parser: assertion failed");

`endif

// ===== rtl/core/tfp_pkg.sv =====
// shared widths, frame byte codes and frame position states
// no dependencies
package tfp_pkg;

  localparam int BYTE_W  = 8;
  localparam int COORD_W = 17;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h26;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h25;
  localparam logic [BYTE_W-1:0] SIGN_MINUS = 8'h2D;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_CKSUM_ERR = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_HDR2   = 9'b000000010,
    S_X_HI   = 9'b000000100,
    S_X_LO   = 9'b000001000,
    S_X_SIGN = 9'b000010000,
    S_Y_HI   = 9'b000100000,
    S_Y_LO   = 9'b001000000,
    S_Y_SIGN = 9'b010000000,
    S_CKSUM  = 9'b100000000
  } frame_state_t;

endpackage

// ===== rtl/core/tfp_if.sv =====
// valid/ready channel interfaces for received bytes and parsed frames
// depends on tfp_pkg
interface tfp_byte_if import tfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfp_frame_if import tfp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      frame_status;
  logic signed [COORD_W-1:0] x_offset;
  logic signed [COORD_W-1:0] y_offset;

  modport source (output valid, output frame_status, output x_offset, output y_offset,
                  input ready);
  modport sink   (input valid, input frame_status, input x_offset, input y_offset,
                  output ready);
endinterface

// ===== rtl/core/target_frame_parser_top.sv =====
// target frame parser: byte-serial parse of the nine-byte target frame
// depends on tfp_pkg, tfp_if and target_frame_parser_top_macros.svh
//
// Takes one received byte per beat and can take a byte in every clock cycle. A frame is
// '&', '%', x high, x low, x sign, y high, y low, y sign and an 8-bit checksum. The
// checksum byte gives one result beat in the cycle after it is accepted: status ok with
// the signed offsets, or status checksum error with both offsets zero. Any other byte
// gives no result; a wrong header byte returns the parser to idle. The result sits in
// an output register; the byte side stalls only while that register holds a result
// that the sink has not taken.
`include "target_frame_parser_top_macros.svh"

module target_frame_parser_top import tfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tfp_byte_if.sink     rx,
  tfp_frame_if.source  result
);

  frame_state_t       state, state_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic [COORD_W-1:0] x_value, x_value_next;
  logic [COORD_W-1:0] y_value, y_value_next;

  logic               out_valid;
  logic               out_status;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;

  logic               rx_fire;
  logic               emit;
  logic               status_next;
  logic [BYTE_W-1:0]  b;

  assign b        = rx.rx_byte;
  assign rx.ready = !out_valid || result.ready;
  assign rx_fire  = rx.valid && rx.ready;

  always_comb begin
    state_next       = state;
    running_sum_next = running_sum;
    x_value_next     = x_value;
    y_value_next     = y_value;
    emit             = 1'b0;
    status_next      = STATUS_OK;
    unique case (state)
      S_IDLE: begin
        state_next = (b == HDR_FIRST) ? S_HDR2 : S_IDLE;
      end
      S_HDR2: begin
        state_next = (b == HDR_SECOND) ? S_X_HI : S_IDLE;
      end
      S_X_HI: begin
        running_sum_next = HDR_FIRST + HDR_SECOND + b;
        x_value_next     = {1'b0, b, {BYTE_W{1'b0}}};
        state_next       = S_X_LO;
      end
      S_X_LO: begin
        running_sum_next = running_sum + b;
        x_value_next     = x_value + COORD_W'(b);
        state_next       = S_X_SIGN;
      end
      S_X_SIGN: begin
        if (b == SIGN_MINUS) begin
          x_value_next = ~x_value + COORD_W'(1);
        end
        running_sum_next = running_sum + b;
        state_next       = S_Y_HI;
      end
      S_Y_HI: begin
        running_sum_next = running_sum + b;
        y_value_next     = {1'b0, b, {BYTE_W{1'b0}}};
        state_next       = S_Y_LO;
      end
      S_Y_LO: begin
        running_sum_next = running_sum + b;
        y_value_next     = y_value + COORD_W'(b);
        state_next       = S_Y_SIGN;
      end
      S_Y_SIGN: begin
        if (b == SIGN_MINUS) begin
          y_value_next = ~y_value + COORD_W'(1);
        end
        running_sum_next = running_sum + b;
        state_next       = S_CKSUM;
      end
      S_CKSUM: begin
        emit = 1'b1;
        if (running_sum != b) begin
          status_next  = STATUS_CKSUM_ERR;
          x_value_next = '0;
          y_value_next = '0;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      running_sum <= '0;
      x_value     <= '0;
      y_value     <= '0;
    end else if (rx_fire) begin
      state       <= state_next;
      running_sum <= running_sum_next;
      x_value     <= x_value_next;
      y_value     <= y_value_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_fire && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && emit) begin
      out_status <= status_next;
      out_x      <= x_value_next;
      out_y      <= y_value_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.frame_status = out_status;
  assign result.x_offset     = $signed(out_x);
  assign result.y_offset     = $signed(out_y);

  `TFP_ASSERT_NOW(a_result_from_cksum, $rose(out_valid), $past(rx_fire && state == S_CKSUM))
  `TFP_ASSERT_NOW(a_err_zero_offsets, out_valid && out_status == STATUS_CKSUM_ERR,
    out_x == '0 && out_y == '0)
  `TFP_ASSERT_NEXT(a_bad_header_idle, rx_fire && state == S_HDR2 && b != HDR_SECOND,
    state == S_IDLE)

endmodule

// ===== tb/target_frame_parser_top_test.sv =====
// testbench for target_frame_parser_top: byte stream in, parsed target frames out
// depends on tfp_pkg, tfp_if and the parser rtl; predicts each frame and checks every result beat
module target_frame_parser_top_test import tfp_pkg::*; ();

  typedef struct {
    logic                      status;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfp_byte_if  rx_ch();
  tfp_frame_if res_ch();

  target_frame_parser_top u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  always #4 clk = ~clk;

  frame_result_t      expected_frames[$];
  frame_state_t       parse_pos = S_IDLE;
  logic [BYTE_W-1:0]  sum_acc = '0;
  logic [COORD_W-1:0] x_acc = '0;
  logic [COORD_W-1:0] y_acc = '0;
  int                 mismatch_count = 0;
  int                 bytes_sent = 0;
  int                 frames_ok = 0;
  int                 frames_bad = 0;
  bit                 src_idle = 1'b1;
  bit                 snk_idle = 1'b1;
  int                 sink_hold = 0;

  function automatic void track_byte(input logic [BYTE_W-1:0] b);
    frame_result_t r;
    case (parse_pos)
      S_IDLE: parse_pos = (b == HDR_FIRST) ? S_HDR2 : S_IDLE;
      S_HDR2: parse_pos = (b == HDR_SECOND) ? S_X_HI : S_IDLE;
      S_X_HI: begin
        sum_acc   = HDR_FIRST + HDR_SECOND + b;
        x_acc     = {1'b0, b, 8'h00};
        parse_pos = S_X_LO;
      end
      S_X_LO: begin
        sum_acc   = sum_acc + b;
        x_acc     = x_acc + b;
        parse_pos = S_X_SIGN;
      end
      S_X_SIGN: begin
        if (b == SIGN_MINUS) x_acc = -x_acc;
        sum_acc   = sum_acc + b;
        parse_pos = S_Y_HI;
      end
      S_Y_HI: begin
        sum_acc   = sum_acc + b;
        y_acc     = {1'b0, b, 8'h00};
        parse_pos = S_Y_LO;
      end
      S_Y_LO: begin
        sum_acc   = sum_acc + b;
        y_acc     = y_acc + b;
        parse_pos = S_Y_SIGN;
      end
      S_Y_SIGN: begin
        if (b == SIGN_MINUS) y_acc = -y_acc;
        sum_acc   = sum_acc + b;
        parse_pos = S_CKSUM;
      end
      S_CKSUM: begin
        if (sum_acc == b) begin
          r.status = STATUS_OK;
          frames_ok++;
        end else begin
          x_acc    = '0;
          y_acc    = '0;
          r.status = STATUS_CKSUM_ERR;
          frames_bad++;
        end
        r.x = x_acc;
        r.y = y_acc;
        expected_frames.push_back(r);
        parse_pos = S_IDLE;
      end
      default: parse_pos = S_IDLE;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_frame();
    frame_result_t want;
    if (expected_frames.size() == 0) begin
      flag_mismatch($sformatf("result beat with none expected: status=%0d x=%0d y=%0d",
                              res_ch.frame_status, res_ch.x_offset, res_ch.y_offset));
      return;
    end
    want = expected_frames.pop_front();
    if (res_ch.frame_status !== want.status)
      flag_mismatch($sformatf("frame_status got %0d want %0d", res_ch.frame_status,
                              want.status));
    if (res_ch.x_offset !== want.x)
      flag_mismatch($sformatf("x_offset got %0d want %0d", res_ch.x_offset, want.x));
    if (res_ch.y_offset !== want.y)
      flag_mismatch($sformatf("y_offset got %0d want %0d", res_ch.y_offset, want.y));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] x_mag, input logic [BYTE_W-1:0] x_sign,
                            input logic [15:0] y_mag, input logic [BYTE_W-1:0] y_sign,
                            input bit corrupt, input int len);
    logic [BYTE_W-1:0] seq [9];
    seq = '{HDR_FIRST, HDR_SECOND, x_mag[15:8], x_mag[7:0], x_sign,
            y_mag[15:8], y_mag[7:0], y_sign, 8'h00};
    for (int i = 0; i < 8; i++) seq[8] = seq[8] + seq[i];
    if (corrupt) seq[8] = seq[8] + 8'($urandom_range(1, 255));
    for (int i = 0; i < len; i++) send_byte(seq[i]);
  endtask

  function automatic logic [15:0] pick_mag();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000 | 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_sign();
    logic [BYTE_W-1:0] s;
    s = 8'($urandom);
    if ($urandom_range(0, 1)) return SIGN_MINUS;
    return (s == SIGN_MINUS) ? 8'h2B : s;
  endfunction

  task automatic wait_all_frames();
    rx_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    send_frame(16'hFFFF, 8'h2B, 16'hFFFF, SIGN_MINUS, 1'b0, 9);
    send_frame(16'h1234, SIGN_MINUS, 16'h00FF, SIGN_MINUS, 1'b1, 9);
    // bad first header, bad second header, repeated first header
    send_byte(8'h00);
    send_byte(HDR_FIRST);
    send_byte(8'h58);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    wait_all_frames();
  endtask

  task automatic test_back_to_back();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    send_frame(16'h0000, SIGN_MINUS, 16'h0000, SIGN_MINUS, 1'b0, 9);
    repeat (9) send_frame(pick_mag(), pick_sign(), pick_mag(), pick_sign(),
                          $urandom_range(0, 3) == 0, 9);
    wait_all_frames();
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  task automatic test_random_stream(input int n_bytes);
    int stop_at;
    int kind;
    int seg;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      seg      = (bytes_sent / 150) % 4;
      src_idle = (seg == 0) || (seg == 2);
      snk_idle = (seg < 2);
      kind     = $urandom_range(0, 99);
      if (kind < 70)
        send_frame(pick_mag(), pick_sign(), pick_mag(), pick_sign(), 1'b0, 9);
      else if (kind < 80)
        send_frame(pick_mag(), pick_sign(), pick_mag(), pick_sign(), 1'b1, 9);
      else if (kind < 90)
        send_frame(pick_mag(), pick_sign(), pick_mag(), pick_sign(), 1'b0,
                   $urandom_range(1, 8));
      else
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
    wait_all_frames();
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  task automatic test_output_stall();
    src_idle  = 1'b0;
    sink_hold = 300;
    repeat (6) send_frame(pick_mag(), pick_sign(), pick_mag(), pick_sign(), 1'b0, 9);
    wait_all_frames();
    src_idle = 1'b1;
  endtask

  initial begin : frame_sink
    int gap;
    res_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      gap = snk_idle ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      check_frame();
    end
  end

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_random_stream(800);
    test_output_stall();
    repeat (20) @(posedge clk);
    $display("sent %0d bytes; %0d frames with good checksum, %0d with bad checksum",
             bytes_sent, frames_ok, frames_bad);
    $display("%0d mismatches, including a long output stall and back-to-back traffic",
             mismatch_count);
    if (mismatch_count == 0 && expected_frames.size() == 0)
      $display("** target_frame_parser_top: PASSED **");
    else
      $display("** target_frame_parser_top: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d frames outstanding", expected_frames.size());
    $display("** target_frame_parser_top: FAILED **");
    $finish;
  end

endmodule

// ===== target_frame_parser_top.f =====
+incdir+rtl/core
rtl/core/tfp_pkg.sv
rtl/core/tfp_if.sv
rtl/core/target_frame_parser_top.sv
tb/target_frame_parser_top_test.sv
